### src/smm_pkg.sv
// Shared types and codes for the small matrix multiplier.
`default_nettype none
package smm_pkg;

    localparam int unsigned IDX_W   = 3;
    localparam int unsigned ELEM_W  = 16;
    localparam int unsigned PROD_W  = 32;
    localparam int unsigned SUM_W   = 40;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_cmd;

    // Element write broadcast to every cell; each cell picks its own slice.
    typedef struct packed {
        logic                     a_we;
        logic                     b_we;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] value;
    } t_wr;

    // Product element in flight along the cell chain.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_tag;

endpackage
`default_nettype wire

### src/smm_seq.sv
// Walks the product elements in row-major order, one per enabled cycle.
`default_nettype none
module smm_seq
    import smm_pkg::*;
#(
    parameter int ROWS = 4,
    parameter int COLS = 2
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_start,
    input  wire  i_en,
    output t_tag o_tag,
    output logic o_busy
);

    logic             r_run;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic             w_row_end;
    logic             w_col_end;

    assign w_row_end = (r_row == IDX_W'(ROWS - 1));
    assign w_col_end = (r_col == IDX_W'(COLS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_row <= '0;
            r_col <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_row <= '0;
            r_col <= '0;
        end else if (r_run && i_en) begin
            if (w_col_end) begin
                r_col <= '0;
                if (w_row_end) begin
                    r_run <= 1'b0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    assign o_tag.valid = r_run;
    assign o_tag.row   = r_row;
    assign o_tag.col   = r_col;
    assign o_tag.last  = w_row_end && w_col_end;
    assign o_busy      = r_run;

endmodule
`default_nettype wire

### src/smm_cell.sv
// One inner-index cell: holds column k of A and row k of B, adds one product term.
`default_nettype none
module smm_cell
    import smm_pkg::*;
#(
    parameter int ROWS     = 4,
    parameter int COLS     = 2,
    parameter int CELL_IDX = 0
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  t_wr                      i_wr,
    input  t_tag                     i_tag,
    input  wire  signed [SUM_W-1:0]  i_psum,
    output t_tag                     o_tag,
    output logic signed [SUM_W-1:0]  o_psum
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

    logic signed [ELEM_W-1:0] r_a [ROWS];
    logic signed [ELEM_W-1:0] r_b [COLS];
    logic signed [ELEM_W-1:0] w_a;
    logic signed [ELEM_W-1:0] w_b;
    t_tag                     r_tag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_psum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < ROWS; n++) begin
                r_a[n] <= '0;
            end
            for (int n = 0; n < COLS; n++) begin
                r_b[n] <= '0;
            end
        end else begin
            if (i_wr.a_we && (i_wr.col == IDX_W'(CELL_IDX))) begin
                r_a[i_wr.row[RW-1:0]] <= i_wr.value;
            end
            if (i_wr.b_we && (i_wr.row == IDX_W'(CELL_IDX))) begin
                r_b[i_wr.col[CW-1:0]] <= i_wr.value;
            end
        end
    end

    assign w_a = r_a[i_tag.row[RW-1:0]];
    assign w_b = r_b[i_tag.col[CW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_a * w_b;
            r_psum <= i_psum;
        end
    end

    assign o_tag  = r_tag;
    assign o_psum = r_psum + SUM_W'(r_prod);

endmodule
`default_nettype wire

### src/small_matrix_multiply.sv
// Small signed matrix multiplier built as a chain of inner-index cells.
//
// Input stream (s_axis): tuser carries the command, tdata the row, column and
// value. Load commands write one element of A or B; a load with an index outside
// its matrix is dropped. A compute command streams all ROWS*COLS elements of
// A x B out on m_axis in row-major order, tlast on the final element.
// Each cell k holds column k of A and row k of B and adds one product term to a
// partial sum passed down the chain, so one element leaves per cycle while the
// receiver keeps up. A compute result passes the sequencer register, each cell
// register and the output register; s_axis_tready stays low while the sequencer
// walks and while the cell chain holds valid elements.
// When the receiver stalls the whole chain holds; a finished result waits in
// the output register while a new load may still be taken.
// Reset clears A and B to zero and empties the chain.
`default_nettype none
module small_matrix_multiply
    import smm_pkg::*;
#(
    parameter int ROWS  = 4,
    parameter int INNER = 3,
    parameter int COLS  = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
    input  wire  [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_row[2:0], out_col[5:3], out_value[45:6], pad
    output logic        m_axis_tlast
);

    logic                     w_accept;
    logic                     w_en;
    logic                     w_start;
    logic                     w_seq_busy;
    logic [INNER-1:0]         w_chain_valid;
    t_wr                      w_wr;
    t_tag                     w_tag  [INNER+1];
    logic signed [SUM_W-1:0]  w_psum [INNER+1];
    logic [IDX_W-1:0]         w_in_row;
    logic [IDX_W-1:0]         w_in_col;
    logic [IDX_W:0]           w_row_x;
    logic [IDX_W:0]           w_col_x;

    logic                     r_out_valid;
    t_tag                     r_out_tag;
    logic signed [SUM_W-1:0]  r_out_value;

    assign w_in_row = s_axis_tdata[2:0];
    assign w_in_col = s_axis_tdata[5:3];
    assign w_row_x  = {1'b0, w_in_row};
    assign w_col_x  = {1'b0, w_in_col};

    assign s_axis_tready = !w_seq_busy && (w_chain_valid == '0);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_en          = !r_out_valid || m_axis_tready;

    always_comb begin
        w_wr       = '0;
        w_wr.row   = w_in_row;
        w_wr.col   = w_in_col;
        w_wr.value = s_axis_tdata[21:6];
        w_start    = 1'b0;
        case (t_cmd'(s_axis_tuser))
            CMD_LOAD_A: begin
                w_wr.a_we = w_accept && (w_row_x < (IDX_W+1)'(ROWS))
                                     && (w_col_x < (IDX_W+1)'(INNER));
            end
            CMD_LOAD_B: begin
                w_wr.b_we = w_accept && (w_row_x < (IDX_W+1)'(INNER))
                                     && (w_col_x < (IDX_W+1)'(COLS));
            end
            CMD_COMPUTE: begin
                w_start = w_accept;
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    smm_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_en    (w_en),
        .o_tag   (w_tag[0]),
        .o_busy  (w_seq_busy)
    );

    assign w_psum[0] = '0;

    for (genvar k = 0; k < INNER; k++) begin : g_cell
        smm_cell #(
            .ROWS     (ROWS),
            .COLS     (COLS),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_wr    (w_wr),
            .i_tag   (w_tag[k]),
            .i_psum  (w_psum[k]),
            .o_tag   (w_tag[k+1]),
            .o_psum  (w_psum[k+1])
        );
        assign w_chain_valid[k] = w_tag[k+1].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tag[INNER].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_tag   <= w_tag[INNER];
            r_out_value <= w_psum[INNER];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_value, r_out_tag.col, r_out_tag.row};
    assign m_axis_tlast  = r_out_tag.last;

    // A compute transfer must start the sequencer in the next cycle.
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_seq_busy)
        else $error("compute transfer did not start the sequencer");

    // No new transfer is taken while product elements are being issued.
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seq_busy |-> !s_axis_tready)
        else $error("input ready while the sequencer runs");

    // The flagged element is exactly the last row and column of the product.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == ((r_out_tag.row == IDX_W'(ROWS - 1))
                                         && (r_out_tag.col == IDX_W'(COLS - 1)))))
        else $error("tlast does not match the final product element");

    // A stalled result must not be overwritten by the chain.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_value)))
        else $error("output register changed while stalled");

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the small matrix multiplier stream block.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import smm_pkg::*;

    localparam int ROWS  = 4;
    localparam int INNER = 3;
    localparam int COLS  = 2;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int DIR_N      = 24;
    localparam int RAND_N     = 250;
    localparam int CALM_N     = 40;
    localparam int LONG_HOLD  = 300;
    localparam int TAIL       = 4 * (ROWS * COLS + INNER + 1);
    // The limit sits well above the slowest run: every item a compute whose
    // results each wait out the longest stall, plus sender gaps.
    localparam int CYCLE_LIMIT = 300000;

    localparam logic signed [SUM_W-1:0] SUM_ZERO    = '0;
    localparam logic signed [SUM_W-1:0] SUM_MIN_SQ  = 40'sd1073741824;
    localparam logic signed [SUM_W-1:0] SUM_MIN_MAX = -40'sd1073709056;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] value;
        logic                     fixed;
        logic signed [SUM_W-1:0]  sum;
    } t_stim;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_elem;

    typedef struct packed {
        logic                    fixed;
        logic signed [SUM_W-1:0] sum;
    } t_known;

    // Typed-in sums hold for every element of that product.
    localparam t_stim DIRECTED [DIR_N] = '{
        '{CMD_COMPUTE, 3'd0, 3'd0, 16'sh0000, 1'b1, SUM_ZERO},
        '{CMD_LOAD_A,  3'd4, 3'd0, 16'sh7FFF, 1'b0, SUM_ZERO},
        '{CMD_LOAD_A,  3'd0, 3'd3, 16'shFFFF, 1'b0, SUM_ZERO},
        '{CMD_LOAD_B,  3'd3, 3'd0, 16'sh7FFF, 1'b0, SUM_ZERO},
        '{CMD_LOAD_B,  3'd0, 3'd2, 16'sh8000, 1'b0, SUM_ZERO},
        '{CMD_LOAD_A,  3'd7, 3'd7, 16'sh8000, 1'b0, SUM_ZERO},
        '{CMD_UNUSED,  3'd0, 3'd0, 16'sh7FFF, 1'b0, SUM_ZERO},
        '{CMD_COMPUTE, 3'd7, 3'd7, 16'shFFFF, 1'b1, SUM_ZERO},
        '{CMD_LOAD_A,  3'd0, 3'd0, 16'sh8000, 1'b0, SUM_ZERO},
        '{CMD_LOAD_A,  3'd1, 3'd0, 16'sh8000, 1'b0, SUM_ZERO},
        '{CMD_LOAD_A,  3'd2, 3'd0, 16'sh8000, 1'b0, SUM_ZERO},
        '{CMD_LOAD_A,  3'd3, 3'd0, 16'sh8000, 1'b0, SUM_ZERO},
        '{CMD_LOAD_B,  3'd0, 3'd0, 16'sh8000, 1'b0, SUM_ZERO},
        '{CMD_LOAD_B,  3'd0, 3'd1, 16'sh8000, 1'b0, SUM_ZERO},
        '{CMD_COMPUTE, 3'd5, 3'd2, 16'sh1234, 1'b1, SUM_MIN_SQ},
        '{CMD_LOAD_B,  3'd0, 3'd0, 16'sh7FFF, 1'b0, SUM_ZERO},
        '{CMD_LOAD_B,  3'd0, 3'd1, 16'sh7FFF, 1'b0, SUM_ZERO},
        '{CMD_COMPUTE, 3'd0, 3'd0, 16'sh0000, 1'b1, SUM_MIN_MAX},
        '{CMD_LOAD_A,  3'd3, 3'd2, 16'sh7FFF, 1'b0, SUM_ZERO},
        '{CMD_LOAD_B,  3'd2, 3'd1, 16'sh7FFF, 1'b0, SUM_ZERO},
        '{CMD_LOAD_A,  3'd1, 3'd1, 16'shFFFF, 1'b0, SUM_ZERO},
        '{CMD_LOAD_B,  3'd1, 3'd0, 16'sh5555, 1'b0, SUM_ZERO},
        '{CMD_LOAD_A,  3'd2, 3'd2, 16'sh8000, 1'b0, SUM_ZERO},
        '{CMD_COMPUTE, 3'd3, 3'd6, 16'shAAAA, 1'b0, SUM_ZERO}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // row[2:0], col[5:3], value[21:6], zero pad
    logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [47:0] m_axis_tdata;        // out_row[2:0], out_col[5:3], out_value[45:6], pad
    wire         m_axis_tlast;

    logic signed [ELEM_W-1:0] a_mat [ROWS][INNER];
    logic signed [ELEM_W-1:0] b_mat [INNER][COLS];
    t_elem  product_q [$];
    t_known known_q [$];

    int  mismatch_cnt = 0;
    int  cycle_cnt = 0;
    bit  tx_gaps = 1'b1;
    bit  rx_gaps = 1'b1;
    bit  hold_req = 1'b0;

    small_matrix_multiply #(
        .ROWS  (ROWS),
        .INNER (INNER),
        .COLS  (COLS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Track the stores on every accepted input transfer and queue the products.
    always @(posedge i_clk) begin : input_monitor
        t_known                  known;
        logic [IDX_W-1:0]        r;
        logic [IDX_W-1:0]        c;
        logic signed [SUM_W-1:0] acc;
        if (!i_rst_n) begin
            foreach (a_mat[i, k]) a_mat[i][k] = '0;
            foreach (b_mat[k, j]) b_mat[k][j] = '0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            known = known_q.pop_front();
            r = s_axis_tdata[2:0];
            c = s_axis_tdata[5:3];
            case (s_axis_tuser)
                CMD_LOAD_A: begin
                    if (r < ROWS && c < INNER) a_mat[r][c] = s_axis_tdata[21:6];
                end
                CMD_LOAD_B: begin
                    if (r < INNER && c < COLS) b_mat[r][c] = s_axis_tdata[21:6];
                end
                CMD_COMPUTE: begin
                    for (int i = 0; i < ROWS; i++) begin
                        for (int j = 0; j < COLS; j++) begin
                            acc = '0;
                            for (int k = 0; k < INNER; k++)
                                acc = acc + a_mat[i][k] * b_mat[k][j];
                            product_q.push_back('{row: IDX_W'(i), col: IDX_W'(j),
                                sum: known.fixed ? known.sum : acc,
                                last: (i == ROWS - 1 && j == COLS - 1)});
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin : output_monitor
        t_elem got;
        t_elem want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{row: m_axis_tdata[2:0], col: m_axis_tdata[5:3],
                    sum: m_axis_tdata[45:6], last: m_axis_tlast};
            if (product_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected product element: row %0d col %0d sum %0d last %0b",
                             got.row, got.col, got.sum, got.last);
            end else begin
                want = product_q.pop_front();
                if (got.row !== want.row || got.col !== want.col ||
                    got.sum !== want.sum || got.last !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("product mismatch: expected row %0d col %0d sum %0d last %0b,",
                                 want.row, want.col, want.sum, want.last,
                                 " got row %0d col %0d sum %0d last %0b",
                                 got.row, got.col, got.sum, got.last);
                end
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin : result_side
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Entered just after a rising edge; returns just after the accepting edge.
    task automatic offer(input t_stim st);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        known_q.push_back('{fixed: st.fixed, sum: st.sum});
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= st.cmd;
        s_axis_tdata  <= {2'b00, st.value, st.col, st.row};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_products_done();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (product_q.size() != 0);
    endtask

    initial begin : stimulus
        t_stim st;
        int    pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIR_N; n++)
            offer(DIRECTED[n]);
        wait_products_done();

        // Keep offering computes while the result side is held off.
        tx_gaps = 1'b0;
        hold_req = 1'b1;
        for (int n = 0; n < 6; n++)
            offer('{cmd: CMD_COMPUTE, row: 3'($urandom), col: 3'($urandom),
                    value: 16'($urandom), fixed: 1'b0, sum: '0});
        tx_gaps = 1'b1;

        for (int n = 0; n < RAND_N; n++) begin
            if (n == RAND_N - CALM_N) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            st = '{cmd: CMD_LOAD_A, row: 3'($urandom), col: 3'($urandom),
                   value: 16'($urandom), fixed: 1'b0, sum: '0};
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                st.cmd = CMD_COMPUTE;
            end else if (pick < 15) begin
                st.cmd = CMD_UNUSED;
            end else if (pick < 25) begin
                st.cmd = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
            end else begin
                // Well-formed load with the index kept inside its matrix.
                if ($urandom_range(0, 1)) begin
                    st.cmd = CMD_LOAD_B;
                    st.row = 3'($urandom_range(0, INNER - 1));
                    st.col = 3'($urandom_range(0, COLS - 1));
                end else begin
                    st.row = 3'($urandom_range(0, ROWS - 1));
                    st.col = 3'($urandom_range(0, INNER - 1));
                end
                case ($urandom_range(0, 11))
                    0: st.value = 16'sh8000;
                    1: st.value = 16'sh7FFF;
                    2: st.value = 16'sh0000;
                    3: st.value = 16'shFFFF;
                    default: ;
                endcase
            end
            offer(st);
        end

        wait_products_done();
        repeat (TAIL) @(posedge i_clk);
        if (mismatch_cnt == 0 && product_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
